// ===== rtl/flt_pkg.sv =====
package flt_pkg;

  localparam int BLOCK_WORDS = 360;
  localparam int CNT_W       = $clog2(BLOCK_WORDS + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] SUM_INIT = 32'h0000_FFFF;
  localparam logic [7:0]  PAD_BYTE = 8'h25;

  typedef struct packed {
    logic        word_valid;
    logic [15:0] word;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [31:0] fold16(input logic [31:0] x);
    logic [16:0] s;
    s = {1'b0, x[15:0]} + {1'b0, x[31:16]};
    return {15'd0, s};
  endfunction

endpackage

// ===== rtl/flt_if.sv =====
interface flt_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

interface flt_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// ===== rtl/fletcher32_string_checksum.sv =====
// Fletcher-32 checksum of a byte string, one byte per beat, one beat per cycle while the
// queue has room. Bytes pair into little-endian words; a beat with last set closes the
// string (an odd byte is padded with 0x25 as the high half) and yields one 32-bit
// checksum with sum2 in the upper half. A beat with neither a byte nor last is ignored.
// The front end pairs bytes and feeds a 4-entry command queue; the accumulator retires
// one word per cycle unless a closing command is stalled; its add-and-block-fold loop
// sets that rate. A checksum passes the finishing and output registers as input flows on.
module fletcher32_string_checksum (
  input logic       clk,
  input logic       rst,
  flt_in_if.sink    in_ch,
  flt_out_if.source out_ch
);

  flt_pkg::cmd_t         push_cmd;
  flt_pkg::cmd_t         pop_cmd;
  flt_pkg::fifo_status_t q_status;
  logic                  push;
  logic                  pop;

  flt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .data_byte (in_ch.data_byte),
    .has_byte  (in_ch.has_byte),
    .last      (in_ch.last),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  flt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  flt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .cmd       (pop_cmd),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .checksum  (out_ch.checksum)
  );

endmodule

// ===== rtl/flt_front.sv =====
module flt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  has_byte,
  input  logic                  last,
  input  flt_pkg::fifo_status_t q_status,
  output logic                  push,
  output flt_pkg::cmd_t         push_cmd
);

  logic       pending_valid;
  logic [7:0] pending_byte;
  logic       pending_valid_next;
  logic [7:0] pending_byte_next;
  logic       beat;

  assign in_ready = !q_status.full;
  assign beat     = in_valid && in_ready;

  always_comb begin
    push               = 1'b0;
    push_cmd           = '0;
    pending_valid_next = pending_valid;
    pending_byte_next  = pending_byte;
    if (beat) begin
      push_cmd.last = last;
      if (has_byte && pending_valid) begin
        push                = 1'b1;
        push_cmd.word_valid = 1'b1;
        push_cmd.word       = {data_byte, pending_byte};
        pending_valid_next  = 1'b0;
      end else if (has_byte) begin
        if (last) begin
          push                = 1'b1;
          push_cmd.word_valid = 1'b1;
          push_cmd.word       = {flt_pkg::PAD_BYTE, data_byte};
        end else begin
          pending_valid_next = 1'b1;
          pending_byte_next  = data_byte;
        end
      end else if (last) begin
        push                = 1'b1;
        push_cmd.word_valid = pending_valid;
        push_cmd.word       = {flt_pkg::PAD_BYTE, pending_byte};
        pending_valid_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else begin
      pending_valid <= pending_valid_next;
    end
    pending_byte <= pending_byte_next;
  end

endmodule

// ===== rtl/flt_fifo.sv =====
module flt_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  flt_pkg::cmd_t         push_cmd,
  input  logic                  pop,
  output flt_pkg::cmd_t         pop_cmd,
  output flt_pkg::fifo_status_t status
);

  localparam int DEPTH = flt_pkg::FIFO_DEPTH;
  localparam int IW    = flt_pkg::FIFO_IDX_W;
  localparam int CW    = flt_pkg::FIFO_CNT_W;

  flt_pkg::cmd_t  mem [DEPTH];
  logic [IW-1:0]  wr_ptr;
  logic [IW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/flt_back.sv =====
module flt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  flt_pkg::fifo_status_t q_status,
  input  flt_pkg::cmd_t         cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           checksum
);

  localparam int CW = flt_pkg::CNT_W;

  logic [31:0]   sum_low;
  logic [31:0]   sum_high;
  logic [CW-1:0] block_count;
  logic [31:0]   sum_low_next;
  logic [31:0]   sum_high_next;
  logic [CW-1:0] block_count_next;
  logic [CW-1:0] cnt_inc;
  logic [31:0]   add_low;
  logic [31:0]   add_high;

  logic          fin_valid;
  logic [31:0]   fin_s1;
  logic [31:0]   fin_s2;
  logic          fin_partial;
  logic [31:0]   f1;
  logic [31:0]   f2;
  logic          out_free;
  logic          fin_ready;

  assign out_free  = !out_valid || out_ready;
  assign fin_ready = !fin_valid || out_free;
  assign pop       = !q_status.empty && (!cmd.last || fin_ready);

  assign add_low  = sum_low + {16'd0, cmd.word};
  assign add_high = sum_high + add_low;
  assign cnt_inc  = block_count + 1'b1;

  always_comb begin
    sum_low_next     = sum_low;
    sum_high_next    = sum_high;
    block_count_next = block_count;
    if (cmd.word_valid) begin
      if (cnt_inc == CW'(flt_pkg::BLOCK_WORDS)) begin
        sum_low_next     = flt_pkg::fold16(add_low);
        sum_high_next    = flt_pkg::fold16(add_high);
        block_count_next = '0;
      end else begin
        sum_low_next     = add_low;
        sum_high_next    = add_high;
        block_count_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low     <= flt_pkg::SUM_INIT;
      sum_high    <= flt_pkg::SUM_INIT;
      block_count <= '0;
    end else if (pop) begin
      if (cmd.last) begin
        sum_low     <= flt_pkg::SUM_INIT;
        sum_high    <= flt_pkg::SUM_INIT;
        block_count <= '0;
      end else begin
        sum_low     <= sum_low_next;
        sum_high    <= sum_high_next;
        block_count <= block_count_next;
      end
    end
  end

  // finishing stage: captured sums, then one or two folds into the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (pop && cmd.last) begin
      fin_valid <= 1'b1;
    end else if (out_free) begin
      fin_valid <= 1'b0;
    end
    if (pop && cmd.last) begin
      fin_s1      <= sum_low_next;
      fin_s2      <= sum_high_next;
      fin_partial <= (block_count_next != '0);
    end
  end

  assign f1 = fin_partial ? flt_pkg::fold16(flt_pkg::fold16(fin_s1)) : flt_pkg::fold16(fin_s1);
  assign f2 = fin_partial ? flt_pkg::fold16(flt_pkg::fold16(fin_s2)) : flt_pkg::fold16(fin_s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
    if (out_free && fin_valid) begin
      checksum <= {f2[15:0], f1[15:0]};
    end
  end

endmodule

// ===== rtl/flt_checker.sv =====
module flt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] checksum
);

  logic [3:0] open_strings;
  logic       in_end;
  logic       out_beat;

  assign in_end   = in_valid && in_ready && in_last;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_strings <= '0;
    end else begin
      case ({in_end, out_beat})
        2'b10:   open_strings <= open_strings + 1'b1;
        2'b01:   open_strings <= open_strings - 1'b1;
        default: open_strings <= open_strings;
      endcase
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> open_strings != 4'd0)
    else $error("result beat without a closed string");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_end && open_strings == 4'd0 |=> !out_valid)
    else $error("result beat too soon after last input beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum))
    else $error("stalled result beat changed");

endmodule

bind fletcher32_string_checksum flt_checker u_flt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .checksum  (out_ch.checksum)
);
